>>> sv/tcp_srt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP segment receive tracker package
// Transfer types, tracker state, action codes and flag constants shared by
// the decision logic and the top level.
// ----------------------------------------------------------------------------
package tcp_srt_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_PORT       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REMOTE_PORT      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_SEND_SEQ = 2'd2;

  localparam logic REQ_SEGMENT = 1'b0;
  localparam logic REQ_SEND    = 1'b1;

  localparam logic [2:0] ACT_IGNORED      = 3'd0;
  localparam logic [2:0] ACT_RESET        = 3'd1;
  localparam logic [2:0] ACT_HANDSHAKE    = 3'd2;
  localparam logic [2:0] ACT_DATA         = 3'd3;
  localparam logic [2:0] ACT_DROPPED      = 3'd4;
  localparam logic [2:0] ACT_ACK_ONLY     = 3'd5;
  localparam logic [2:0] ACT_SEND_OK      = 3'd6;
  localparam logic [2:0] ACT_SEND_REFUSED = 3'd7;

  localparam int FLAG_FIN_BIT = 0;
  localparam int FLAG_SYN_BIT = 1;
  localparam int FLAG_RST_BIT = 2;
  localparam int FLAG_PSH_BIT = 3;
  localparam int FLAG_ACK_BIT = 4;

  localparam logic [7:0] FLAGS_ACK     = 8'h10;
  localparam logic [7:0] FLAGS_ACK_PSH = 8'h18;

  localparam logic [15:0] MIN_SEGMENT_LEN = 16'd20;
  localparam logic [3:0]  MIN_DATA_OFFSET = 4'd5;

  typedef struct packed {
    logic        req_type;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [3:0]  data_offset;
    logic [7:0]  flags;
    logic [15:0] segment_length;
    logic [15:0] sent_count;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        send_ack;
    logic [7:0]  reply_flags;
    logic [31:0] reply_seq;
    logic [31:0] reply_ack;
    logic        accept_payload;
    logic [15:0] payload_bytes;
    logic        is_established;
    logic        peer_is_closed;
    logic [31:0] dropped_segment_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] recv_next;
    logic [31:0] send_next;
    logic        established;
    logic        peer_closed;
    logic [31:0] dropped_segments;
  } conn_state_t;

endpackage

>>> sv/tcp_srt_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP segment receive tracker decision logic
// Combinational evaluation of one item against the connection state: send
// accounting, header checks, RST, handshake, in-order acceptance, drops, FIN.
// ----------------------------------------------------------------------------
module tcp_srt_eval
  import tcp_srt_pkg::*;
(
  input  req_t        item,
  input  conn_state_t st,
  input  logic [15:0] local_port,
  input  logic [15:0] remote_port,
  output rsp_t        result,
  output conn_state_t st_next
);

  logic [5:0]  hdr_len;
  logic        hdr_ok;
  logic [15:0] pay;
  logic        has_pay;
  logic        in_order;
  logic [31:0] recv_adv;
  logic [31:0] recv_mid;
  logic [31:0] fin_diff;
  logic [31:0] fin_next;
  logic [31:0] syn_next;

  assign hdr_len  = {item.data_offset, 2'b00};
  assign hdr_ok   = (item.segment_length >= MIN_SEGMENT_LEN) &&
                    (item.dst_port == local_port) &&
                    (item.src_port == remote_port) &&
                    (item.data_offset >= MIN_DATA_OFFSET) &&
                    ({10'd0, hdr_len} <= item.segment_length);
  assign pay      = item.segment_length - {10'd0, hdr_len};
  assign has_pay  = (pay != 16'd0);
  assign in_order = (item.seq_num == st.recv_next);
  assign recv_adv = st.recv_next + {16'd0, pay};
  assign recv_mid = (has_pay && in_order) ? recv_adv : st.recv_next;
  assign fin_diff = recv_mid - item.seq_num;
  assign fin_next = item.seq_num + {16'd0, pay} + 32'd1;
  assign syn_next = item.seq_num + 32'd1;

  always_comb begin
    st_next = st;
    result  = '0;
    if (item.req_type == REQ_SEND) begin
      if (st.established) begin
        st_next.send_next = st.send_next + {16'd0, item.sent_count};
        result.action     = ACT_SEND_OK;
      end else begin
        result.action = ACT_SEND_REFUSED;
      end
    end else if (hdr_ok) begin
      priority if (item.flags[FLAG_RST_BIT]) begin
        st_next.peer_closed = 1'b1;
        result.action       = ACT_RESET;
      end else if (!item.flags[FLAG_ACK_BIT] && !item.flags[FLAG_SYN_BIT]) begin
        result.action = ACT_IGNORED;
      end else if (item.flags[FLAG_ACK_BIT] && item.flags[FLAG_SYN_BIT]) begin
        if (!st.established) begin
          st_next.recv_next    = syn_next;
          st_next.send_next    = item.ack_num;
          st_next.established  = 1'b1;
          result.action        = ACT_HANDSHAKE;
          result.send_ack      = 1'b1;
          result.reply_flags   = FLAGS_ACK;
          result.reply_seq     = item.ack_num;
          result.reply_ack     = syn_next;
          result.payload_bytes = pay;
        end
      end else begin
        result.action        = ACT_ACK_ONLY;
        result.payload_bytes = pay;
        if (has_pay) begin
          result.send_ack  = 1'b1;
          result.reply_seq = st.send_next;
          result.reply_ack = recv_mid;
          if (in_order) begin
            st_next.recv_next     = recv_adv;
            result.accept_payload = 1'b1;
            result.action         = ACT_DATA;
            result.reply_flags    = FLAGS_ACK_PSH;
          end else begin
            st_next.dropped_segments = st.dropped_segments + 32'd1;
            result.action            = ACT_DROPPED;
            result.reply_flags       = FLAGS_ACK;
          end
        end
        if (item.flags[FLAG_FIN_BIT]) begin
          if (!fin_diff[31] || !has_pay) begin
            st_next.recv_next = fin_next;
          end
          st_next.peer_closed = 1'b1;
        end
      end
    end
    result.is_established        = st_next.established;
    result.peer_is_closed        = st_next.peer_closed;
    result.dropped_segment_count = st_next.dropped_segments;
  end

endmodule

>>> sv/tcp_segment_receive_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP segment receive tracker
// Tracks the receive side of one client TCP connection and decides, per
// segment, whether payload is taken, dropped or acknowledged.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries either a parsed received segment header or a note
// of locally sent bytes; a transfer happens when req_valid is high and
// req_stall is low. Every request gives exactly one result on the rsp
// channel, transferred when rsp_valid is high and rsp_stall is low.
// An item is held in the input register, is evaluated against the
// connection state, and its result is then captured in the output
// register. One item per cycle is sustained while rsp_stall stays low;
// the only loop is the registered state update of the evaluator.
// When the receiver stalls, the result holds, the input register keeps one
// more item, and req_stall rises only while both are occupied.
// Synchronous reset clears the connection state, the port registers and
// both valid flags. The configuration port takes a write in any cycle;
// writing the initial send sequence also loads the send sequence.
// ----------------------------------------------------------------------------
module tcp_segment_receive_tracker_core
  import tcp_srt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output rsp_t                   rsp
);

  logic        item_valid;
  req_t        item;
  conn_state_t st;
  conn_state_t st_next;
  conn_state_t st_cfg_next;
  rsp_t        result;
  logic [15:0] local_port;
  logic [15:0] remote_port;
  logic        advance;
  logic        fire;
  logic        take;

  assign advance   = !rsp_valid || !rsp_stall;
  assign fire      = item_valid && advance;
  assign req_stall = item_valid && !advance;
  assign take      = req_valid && !req_stall;

  tcp_srt_eval u_eval (
    .item        (item),
    .st          (st),
    .local_port  (local_port),
    .remote_port (remote_port),
    .result      (result),
    .st_next     (st_next)
  );

  always_comb begin
    st_cfg_next = fire ? st_next : st;
    if (cfg_we && (cfg_index == CFG_INITIAL_SEND_SEQ)) begin
      st_cfg_next.send_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
    if (take) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= '0;
      local_port  <= '0;
      remote_port <= '0;
    end else begin
      st <= st_cfg_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOCAL_PORT:  local_port  <= cfg_data[15:0];
          CFG_REMOTE_PORT: remote_port <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (advance) begin
      rsp_valid <= 1'b0;
    end
    if (fire) begin
      rsp <= result;
    end
  end

  a_established_sticky: assert property (@(posedge clk) disable iff (rst)
    st.established |=> st.established)
    else $error("Established flag cleared without reset.");

  a_refused_send_keeps_seq: assert property (@(posedge clk) disable iff (rst)
    (fire && item.req_type == REQ_SEND && !st.established && !cfg_we) |=>
      ($stable(st.send_next) && rsp.action == ACT_SEND_REFUSED))
    else $error("Refused send changed the send sequence.");

  a_drop_count_matches: assert property (@(posedge clk) disable iff (rst)
    fire |=> ((st.dropped_segments == $past(st.dropped_segments) + 32'd1) ==
              (rsp.action == ACT_DROPPED)))
    else $error("Drop counter and dropped action disagree.");

  a_reply_has_ack: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.send_ack) |-> rsp.reply_flags[FLAG_ACK_BIT])
    else $error("Reply requested without the ACK flag.");

  a_accept_is_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.accept_payload) |->
      (rsp.action == ACT_DATA && rsp.payload_bytes != 16'd0))
    else $error("Payload accepted outside an in-order data segment.");

endmodule
